>>> hw/rtl/fmta_pkg.sv
// Shared constants and types for the flow meter with trigger and aging.
package fmta_pkg;

  localparam int unsigned DefaultEntries = 16;

  localparam logic [31:0] SizeTriggerReset = 32'd2048;
  localparam logic [31:0] AgeTriggerReset = 32'd60000;
  localparam logic [31:0] IdleTimeoutReset = 32'd30000;

  localparam logic [7:0] ProtoShim6 = 8'd140;
  localparam logic [7:0] ProtoIcmpv6 = 8'd58;
  localparam logic [7:0] MulticastTop = 8'hff;

  localparam logic [1:0] CmdTick = 2'd0;
  localparam logic [1:0] CmdInbound = 2'd1;
  localparam logic [1:0] CmdOutbound = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] RegSizeTrigger = 2'd0;
  localparam logic [1:0] RegAgeTrigger = 2'd1;
  localparam logic [1:0] RegIdleTimeout = 2'd2;

  localparam logic [2:0] StFiltered = 3'd0;
  localparam logic [2:0] StNoEntry = 3'd1;
  localparam logic [2:0] StCreated = 3'd2;
  localparam logic [2:0] StUpdated = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StTickDone = 3'd5;

  localparam logic [4:0] ExpiredMax = 5'd31;

  // One flow entry as held in the table memory.
  typedef struct packed {
    logic [63:0] local_high;
    logic [63:0] local_low;
    logic [63:0] peer_high;
    logic [63:0] peer_low;
    logic [31:0] iface;
    logic [31:0] bytes;
    logic [31:0] created;
    logic [31:0] seen;
    logic        fired;
  } entry_t;

endpackage

>>> hw/rtl/fmta_table.sv
// Flow table memory with one write port and one registered read port.
module fmta_table import fmta_pkg::*; #(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr,
  input  entry_t                                        wdata,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr,
  output entry_t                                        rdata
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/flow_meter_with_trigger_and_aging_top.sv
// Top level of the flow meter with one-shot trigger and idle aging.
//
// A word is given on the input ports with start high while busy is low.
// Every word produces exactly one result, shown for one cycle with done high.
// Unfiltered packets and ticks scan the flow table held in one synchronous
// memory, one entry per cycle. A scanned word raises done from S_DECIDE
// when it is a tick, finds no entry, finds the table full or creates an
// entry; an update of an existing entry goes on through S_READ and S_WRITE
// to read it back and write it. A filtered packet or an unused command
// raises done on the next cycle. A new word may be accepted in the cycle
// that done is high. Configuration is written through cfg_we, cfg_index
// and cfg_data and takes effect at once; the user must write it only while
// the block is idle, which the block does not enforce. Reset clears all
// valid bits, the tick counter and restores the register defaults; table
// contents are not cleared since each entry is written before it is used.
// The receiver cannot stall; done is a strobe and the result ports hold until
// the next word is accepted. Valid bits are flip-flops and clear at reset.
module flow_meter_with_trigger_and_aging_top import fmta_pkg::*; #(
  parameter int unsigned ENTRIES = DefaultEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  command,
  input  logic [63:0] src_addr_high,
  input  logic [63:0] src_addr_low,
  input  logic [63:0] dst_addr_high,
  input  logic [63:0] dst_addr_low,
  input  logic [7:0]  first_next_header,
  input  logic [7:0]  upper_protocol,
  input  logic [15:0] packet_length,
  input  logic [31:0] interface_index,
  output logic [2:0]  status,
  output logic        trigger,
  output logic [63:0] trig_local_high,
  output logic [63:0] trig_local_low,
  output logic [63:0] trig_peer_high,
  output logic [63:0] trig_peer_low,
  output logic [31:0] trig_interface,
  output logic [4:0]  expired_count
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned AW = IW;
  localparam logic [AW-1:0] Last = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_READ, S_WRITE} state_t;

  state_t state;
  logic [31:0] size_trig, age_trig, idle_to, now_ticks;
  logic [ENTRIES-1:0] valid;
  logic [1:0]  cmd;
  logic [63:0] lh, ll, ph, pl;
  logic [15:0] len;
  logic [31:0] ifx;
  logic [AW-1:0] raddr, cmp_idx, hit_idx, free_idx;
  logic cmp_pending, hit_found, free_found;
  logic [4:0] freed;
  entry_t rdata, wdata;
  logic we;
  logic [AW-1:0] waddr;
  logic any_local, key_match, idle_hit, filt;
  logic [32:0] bsum;
  logic [31:0] bsat;
  logic fire_upd, fire_new;

  fmta_table #(.ENTRIES(ENTRIES)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign any_local = (lh == 64'd0) && (ll == 64'd0);
  assign key_match = valid[IW'(cmp_idx)] && rdata.peer_high == ph && rdata.peer_low == pl
                     && (any_local || (rdata.local_high == lh && rdata.local_low == ll));
  assign idle_hit = valid[IW'(cmp_idx)] && ((now_ticks - rdata.seen) >= idle_to);
  assign filt = first_next_header == ProtoShim6 || upper_protocol == ProtoIcmpv6
                || dst_addr_high[63:56] == MulticastTop;
  assign bsum = {1'b0, rdata.bytes} + {17'd0, len};
  assign bsat = bsum[32] ? 32'hffff_ffff : bsum[31:0];
  assign fire_upd = !rdata.fired
                    && (bsat >= size_trig || (now_ticks - rdata.created) >= age_trig);
  assign fire_new = ({16'd0, len} >= size_trig) || (age_trig == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      we <= 1'b0;
      valid <= '0;
      now_ticks <= '0;
      size_trig <= SizeTriggerReset;
      age_trig <= AgeTriggerReset;
      idle_to <= IdleTimeoutReset;
      cmp_pending <= 1'b0;
    end else begin
      done <= 1'b0;
      we <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          RegSizeTrigger: size_trig <= cfg_data;
          RegAgeTrigger:  age_trig <= cfg_data;
          RegIdleTimeout: idle_to <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd <= command;
            len <= packet_length;
            ifx <= interface_index;
            if (command == CmdInbound) begin
              lh <= dst_addr_high; ll <= dst_addr_low;
              ph <= src_addr_high; pl <= src_addr_low;
            end else begin
              lh <= src_addr_high; ll <= src_addr_low;
              ph <= dst_addr_high; pl <= dst_addr_low;
            end
            status <= StFiltered; trigger <= 1'b0;
            trig_local_high <= '0; trig_local_low <= '0;
            trig_peer_high <= '0; trig_peer_low <= '0;
            trig_interface <= '0; expired_count <= '0;
            if (command == CmdTick || ((command == CmdInbound || command == CmdOutbound)
                                       && !filt)) begin
              if (command == CmdTick) now_ticks <= now_ticks + 32'd1;
              raddr <= '0;
              hit_found <= 1'b0;
              free_found <= 1'b0;
              freed <= '0;
              cmp_pending <= 1'b0;
              busy <= 1'b1;
              state <= S_SCAN;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (raddr != Last) raddr <= raddr + AW'(1);
          cmp_idx <= raddr;
          cmp_pending <= !(cmp_pending && cmp_idx == Last);
          if (cmp_pending) begin
            if (cmd == CmdTick) begin
              if (idle_hit) begin
                valid[IW'(cmp_idx)] <= 1'b0;
                if (freed != ExpiredMax) freed <= freed + 5'd1;
              end
            end else begin
              if (key_match && !hit_found) begin
                hit_found <= 1'b1; hit_idx <= cmp_idx;
              end
              if (!valid[IW'(cmp_idx)] && !free_found) begin
                free_found <= 1'b1; free_idx <= cmp_idx;
              end
            end
            if (cmp_idx == Last) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (cmd == CmdTick) begin
            status <= StTickDone;
            expired_count <= freed;
            busy <= 1'b0; done <= 1'b1; state <= S_IDLE;
          end else if (hit_found) begin
            raddr <= hit_idx;
            state <= S_READ;
          end else if (cmd == CmdInbound) begin
            status <= StNoEntry;
            busy <= 1'b0; done <= 1'b1; state <= S_IDLE;
          end else if (!free_found) begin
            status <= StFull;
            busy <= 1'b0; done <= 1'b1; state <= S_IDLE;
          end else begin
            we <= 1'b1; waddr <= free_idx;
            wdata.local_high <= lh; wdata.local_low <= ll;
            wdata.peer_high <= ph; wdata.peer_low <= pl;
            wdata.iface <= ifx; wdata.bytes <= {16'd0, len};
            wdata.created <= now_ticks; wdata.seen <= now_ticks;
            wdata.fired <= fire_new;
            valid[IW'(free_idx)] <= 1'b1;
            status <= StCreated;
            if (fire_new) begin
              trigger <= 1'b1;
              trig_local_high <= lh; trig_local_low <= ll;
              trig_peer_high <= ph; trig_peer_low <= pl;
              trig_interface <= ifx;
            end
            busy <= 1'b0; done <= 1'b1; state <= S_IDLE;
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          we <= 1'b1; waddr <= hit_idx;
          wdata.local_high <= rdata.local_high; wdata.local_low <= rdata.local_low;
          wdata.peer_high <= rdata.peer_high; wdata.peer_low <= rdata.peer_low;
          wdata.iface <= rdata.iface; wdata.created <= rdata.created;
          wdata.bytes <= bsat;
          wdata.seen <= now_ticks;
          wdata.fired <= rdata.fired || fire_upd;
          status <= StUpdated;
          if (fire_upd) begin
            trigger <= 1'b1;
            trig_local_high <= rdata.local_high; trig_local_low <= rdata.local_low;
            trig_peer_high <= rdata.peer_high; trig_peer_low <= rdata.peer_low;
            trig_interface <= rdata.iface;
          end
          busy <= 1'b0; done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_trig_status: assert property (@(posedge clk) disable iff (rst)
    (done && trigger) |-> (status == StCreated || status == StUpdated))
    else $error("trigger with wrong status");
  a_exp_tick: assert property (@(posedge clk) disable iff (rst)
    (done && status != StTickDone) |-> expired_count == 5'd0)
    else $error("expired count outside tick");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && state == S_IDLE) |=> (busy || done))
    else $error("word lost");

endmodule

>>> dv/flow_meter_with_trigger_and_aging_checker.sv
// Checker that predicts flow meter results from accepted words and compares them.
module flow_meter_with_trigger_and_aging_checker import fmta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  command,
  input  logic [63:0] src_addr_high,
  input  logic [63:0] src_addr_low,
  input  logic [63:0] dst_addr_high,
  input  logic [63:0] dst_addr_low,
  input  logic [7:0]  first_next_header,
  input  logic [7:0]  upper_protocol,
  input  logic [15:0] packet_length,
  input  logic [31:0] interface_index,
  input  logic [2:0]  status,
  input  logic        trigger,
  input  logic [63:0] trig_local_high,
  input  logic [63:0] trig_local_low,
  input  logic [63:0] trig_peer_high,
  input  logic [63:0] trig_peer_low,
  input  logic [31:0] trig_interface,
  input  logic [4:0]  expired_count,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic        trigger;
    logic [63:0] lh;
    logic [63:0] ll;
    logic [63:0] ph;
    logic [63:0] pl;
    logic [31:0] ifc;
    logic [4:0]  expired;
  } flow_result_t;

  flow_result_t expected_results[$];
  logic [31:0] size_thr, age_thr, idle_thr, now;
  logic        valid [16];
  entry_t      table_q [16];

  assign pending = expected_results.size();

  function automatic int lookup_flow(logic [63:0] lh, ll, ph, pl);
    for (int i = 0; i < 16; i++) begin
      if (valid[i] && table_q[i].peer_high == ph && table_q[i].peer_low == pl &&
          ((lh == 0 && ll == 0) || (table_q[i].local_high == lh && table_q[i].local_low == ll)))
        return i;
    end
    return -1;
  endfunction

  function automatic logic check_fire(int i);
    if (table_q[i].fired) return 1'b0;
    if (table_q[i].bytes >= size_thr || (now - table_q[i].created) >= age_thr) begin
      table_q[i].fired = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic flow_result_t meter_word();
    flow_result_t r;
    int hit;
    int slot;
    logic fire;
    logic [32:0] sum;
    r = '0;
    fire = 1'b0;
    slot = -1;
    if (command == CmdTick) begin
      now = now + 32'd1;
      for (int i = 0; i < 16; i++) begin
        if (valid[i] && (now - table_q[i].seen) >= idle_thr) begin
          valid[i] = 1'b0;
          if (r.expired < ExpiredMax) r.expired = r.expired + 5'd1;
        end
      end
      r.status = StTickDone;
      return r;
    end
    if (command != CmdInbound && command != CmdOutbound) return r;
    if (first_next_header == ProtoShim6 || upper_protocol == ProtoIcmpv6 ||
        dst_addr_high[63:56] == MulticastTop) return r;
    if (command == CmdInbound) begin
      hit = lookup_flow(dst_addr_high, dst_addr_low, src_addr_high, src_addr_low);
      if (hit < 0) begin
        r.status = StNoEntry;
        return r;
      end
    end else begin
      hit = lookup_flow(src_addr_high, src_addr_low, dst_addr_high, dst_addr_low);
      if (hit < 0) begin
        for (int i = 15; i >= 0; i--) if (!valid[i]) slot = i;
        if (slot < 0) begin
          r.status = StFull;
          return r;
        end
        hit = slot;
        valid[hit] = 1'b1;
        table_q[hit].local_high = src_addr_high;
        table_q[hit].local_low = src_addr_low;
        table_q[hit].peer_high = dst_addr_high;
        table_q[hit].peer_low = dst_addr_low;
        table_q[hit].iface = interface_index;
        table_q[hit].bytes = {16'd0, packet_length};
        table_q[hit].created = now;
        table_q[hit].seen = now;
        table_q[hit].fired = 1'b0;
        fire = check_fire(hit);
        r.status = StCreated;
      end
    end
    if (r.status != StCreated) begin
      sum = {1'b0, table_q[hit].bytes} + {17'd0, packet_length};
      table_q[hit].bytes = sum[32] ? 32'hffffffff : sum[31:0];
      table_q[hit].seen = now;
      fire = check_fire(hit);
      r.status = StUpdated;
    end
    if (fire) begin
      r.trigger = 1'b1;
      r.lh = table_q[hit].local_high;
      r.ll = table_q[hit].local_low;
      r.ph = table_q[hit].peer_high;
      r.pl = table_q[hit].peer_low;
      r.ifc = table_q[hit].iface;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    flow_result_t e;
    if (rst) begin
      size_thr = SizeTriggerReset;
      age_thr = AgeTriggerReset;
      idle_thr = IdleTimeoutReset;
      now = '0;
      for (int i = 0; i < 16; i++) valid[i] = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegSizeTrigger: size_thr = cfg_data;
          RegAgeTrigger: age_thr = cfg_data;
          RegIdleTimeout: idle_thr = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          fail_count = fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status);
            fail_count = fail_count + 1;
          end
          if (trigger !== e.trigger) begin
            $error("trigger expected %0d actual %0d", e.trigger, trigger);
            fail_count = fail_count + 1;
          end
          if (trig_local_high !== e.lh) begin
            $error("trig_local_high expected %h actual %h", e.lh, trig_local_high);
            fail_count = fail_count + 1;
          end
          if (trig_local_low !== e.ll) begin
            $error("trig_local_low expected %h actual %h", e.ll, trig_local_low);
            fail_count = fail_count + 1;
          end
          if (trig_peer_high !== e.ph) begin
            $error("trig_peer_high expected %h actual %h", e.ph, trig_peer_high);
            fail_count = fail_count + 1;
          end
          if (trig_peer_low !== e.pl) begin
            $error("trig_peer_low expected %h actual %h", e.pl, trig_peer_low);
            fail_count = fail_count + 1;
          end
          if (trig_interface !== e.ifc) begin
            $error("trig_interface expected %h actual %h", e.ifc, trig_interface);
            fail_count = fail_count + 1;
          end
          if (expired_count !== e.expired) begin
            $error("expired_count expected %0d actual %0d", e.expired, expired_count);
            fail_count = fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(meter_word());
    end
  end
endmodule

>>> dv/flow_meter_with_trigger_and_aging_top_test.sv
// Testbench top that drives words and configuration into the flow meter.
module flow_meter_with_trigger_and_aging_top_test;
  import fmta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic [1:0]  command = '0;
  logic [63:0] src_addr_high = '0, src_addr_low = '0, dst_addr_high = '0, dst_addr_low = '0;
  logic [7:0]  first_next_header = '0, upper_protocol = '0;
  logic [15:0] packet_length = '0;
  logic [31:0] interface_index = '0;
  logic [2:0]  status;
  logic        trigger;
  logic [63:0] trig_local_high, trig_local_low, trig_peer_high, trig_peer_low;
  logic [31:0] trig_interface;
  logic [4:0]  expired_count;
  int          fail_count, pending;
  logic [63:0] pool_h [4], pool_l [4];

  always #5 clk = ~clk;

  flow_meter_with_trigger_and_aging_top u_top (.*);
  flow_meter_with_trigger_and_aging_checker u_chk (.*);

  task automatic send_word(logic [1:0] cmd, logic [63:0] sh, sl, dh, dl,
                           logic [7:0] nh, up, logic [15:0] len, logic [31:0] ifx);
    command <= cmd;
    src_addr_high <= sh;
    src_addr_low <= sl;
    dst_addr_high <= dh;
    dst_addr_low <= dl;
    first_next_header <= nh;
    upper_protocol <= up;
    packet_length <= len;
    interface_index <= ifx;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_word();
    int k;
    logic [1:0] cmd;
    logic [63:0] ah, al, bh, bl;
    logic [7:0] nh, up;
    k = $urandom_range(0, 99);
    cmd = (k < 15) ? CmdTick : (k < 55) ? CmdOutbound : (k < 95) ? CmdInbound : CmdUnused;
    ah = pool_h[$urandom_range(0, 3)];
    al = pool_l[$urandom_range(0, 3)];
    bh = pool_h[$urandom_range(0, 3)];
    bl = pool_l[$urandom_range(0, 3)];
    if ($urandom_range(0, 9) == 0) begin
      ah = {$urandom, $urandom};
      bh = {$urandom, $urandom};
    end
    if ($urandom_range(0, 7) == 0) begin
      ah = '0;
      al = '0;
    end
    nh = 8'($urandom);
    up = 8'($urandom);
    if ($urandom_range(0, 9) == 0) nh = ProtoShim6;
    if ($urandom_range(0, 9) == 0) up = ProtoIcmpv6;
    if (nh == ProtoShim6 && $urandom_range(0, 1)) nh = 8'd6;
    if (cmd == CmdInbound) send_word(cmd, bh, bl, ah, al, nh, up, 16'($urandom), $urandom);
    else send_word(cmd, ah, al, bh, bl, nh, up, 16'($urandom), $urandom);
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      pool_h[i] = {$urandom, $urandom} & 64'h7fffffffffffffff;
      pool_l[i] = {$urandom, $urandom};
    end
    pool_h[3] = 64'hfe7fffffffffffff;
    pool_l[3] = '1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_word(CmdOutbound, '1, '1, 64'h7fff_ffff_ffff_ffff, '1, 8'd6, 8'd17, 16'hffff, '1);
    send_word(CmdOutbound, '0, '0, 64'h1, 64'h2, 8'd255, 8'd255, 16'd0, 32'd0);
    send_word(CmdInbound, 64'h1, 64'h2, '0, '0, 8'd0, 8'd0, 16'd10, 32'd5);
    send_word(CmdInbound, 64'h7fff_ffff_ffff_ffff, '1, 64'h5, 64'h6, 8'd0, 8'd0, 16'd1, 32'd1);
    send_word(CmdInbound, 64'h7fff_ffff_ffff_ffff, '1, '0, '0, 8'd0, 8'd0, 16'd1, 32'd1);
    send_word(CmdOutbound, 64'h3, 64'h4, 64'hff00_0000_0000_0001, 64'h1, 8'd0, 8'd0, 16'd1, 32'd1);
    send_word(CmdOutbound, 64'h3, 64'h4, 64'h5, 64'h1, ProtoShim6, 8'd0, 16'd1, 32'd1);
    send_word(CmdOutbound, 64'h3, 64'h4, 64'h5, 64'h1, 8'd0, ProtoIcmpv6, 16'd1, 32'd1);
    send_word(CmdUnused, '1, '1, '1, '1, '1, '1, '1, '1);
    send_word(CmdTick, '0, '0, '0, '0, 8'd0, 8'd0, 16'd0, 32'd0);
    drain();
    write_reg(RegSizeTrigger, 32'hffffffff);
    write_reg(RegAgeTrigger, 32'd0);
    write_reg(RegIdleTimeout, 32'd3);
    for (int i = 0; i < 17; i++)
      send_word(CmdOutbound, 64'h10 + i, 64'h0, 64'h20, 64'h0, 8'd0, 8'd0, 16'hffff, i);
    for (int i = 0; i < 3; i++) send_word(CmdTick, '0, '0, '0, '0, 8'd0, 8'd0, 16'd0, 32'd0);
    drain();
    write_reg(RegIdleTimeout, 32'd0);
    write_reg(RegAgeTrigger, 32'hffffffff);
    send_word(CmdOutbound, 64'h1, 64'h1, 64'h2, 64'h2, 8'd0, 8'd0, 16'hffff, 32'd9);
    send_word(CmdTick, '0, '0, '0, '0, 8'd0, 8'd0, 16'd0, 32'd0);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(RegSizeTrigger, phase == 0 ? 32'd0 : $urandom_range(100, 300000));
      write_reg(RegAgeTrigger, phase == 1 ? 32'd1 : $urandom_range(2, 40));
      write_reg(RegIdleTimeout, phase == 2 ? 32'hffffffff : $urandom_range(1, 30));
      for (int n = 0; n < 100; n++) begin
        random_word();
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 40)) @(negedge clk);
      end
      drain();
    end
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
